### hw/rtl/ifla_pkg.sv
// Package for the implicit free-list allocator: sizes, codes and work-item type.
// Depends on nothing; every other file of the allocator but ifla_ram uses it by scoped names.
package ifla_pkg;

   localparam int REGION_GRANULES = 4096;
   localparam int GRANULE_BYTES   = 8;
   localparam int PAGE_GRANULES   = 512;

   localparam int PAGES_W     = 4;
   localparam int RESET_PAGES = 8;
   localparam int CMD_W       = 1;
   localparam int BYTES_W     = 15;
   localparam int STYLE_W     = 2;
   localparam int ADDR_W      = 15;
   localparam int STATUS_W    = 2;
   // granules needed by the largest request, header included
   localparam int NEED_W      = 13;
   // granule index carried by a free address
   localparam int GRAN_W      = 12;

   localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
   localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

   localparam logic [STYLE_W-1:0] FIT_FIRST = 2'd0;
   localparam logic [STYLE_W-1:0] FIT_BEST  = 2'd1;
   localparam logic [STYLE_W-1:0] FIT_WORST = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_NULL     = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_REPLY = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [STYLE_W-1:0]   style;
      logic [NEED_W-1:0]    need;
      logic [GRAN_W-1:0]    gran;
      status_type           status;
   } work_type;

   // Region size in granules for a page count, capped at rg; zero pages acts as one.
   function automatic logic [31:0] region_granules(logic [PAGES_W-1:0] pages, int rg, int pg);
      logic [31:0] p;
      logic [31:0] prod;
      p    = (pages == '0) ? 32'd1 : 32'(pages);
      prod = p * 32'(pg);
      return (prod > 32'(rg)) ? 32'(rg) : prod;
   endfunction

endpackage

### hw/rtl/ifla_req_if.sv
// Request channel interface of the allocator: valid/ready plus request fields.
// Depends on ifla_pkg for field widths.
interface ifla_req_if;
   logic                          valid;
   logic                          ready;
   logic [ifla_pkg::CMD_W-1:0]    command;
   logic [ifla_pkg::BYTES_W-1:0]  request_bytes;
   logic [ifla_pkg::STYLE_W-1:0]  fit_style;
   logic [ifla_pkg::ADDR_W-1:0]   free_address;

   modport source (output valid, command, request_bytes, fit_style, free_address,
                   input ready);
   modport sink (input valid, command, request_bytes, fit_style, free_address,
                 output ready);
endinterface

### hw/rtl/ifla_rsp_if.sv
// Response channel interface of the allocator: valid/ready plus result fields.
// Depends on ifla_pkg for field widths.
interface ifla_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [ifla_pkg::STATUS_W-1:0]  status;
   logic [ifla_pkg::ADDR_W-1:0]    payload_address;

   modport source (output valid, status, payload_address, input ready);
   modport sink (input valid, status, payload_address, output ready);
endinterface

### hw/rtl/ifla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ifla_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ifla_front.sv
// Front end: takes request beats and classifies them into work items.
// Depends on ifla_pkg and ifla_req_if.
module ifla_front #(
   parameter int REGION_GRANULES = ifla_pkg::REGION_GRANULES
) (
   ifla_req_if.sink                        req_if,
   input  logic [$clog2(REGION_GRANULES):0] region_limit,
   input  logic                            q_full,
   output logic                            q_push,
   output ifla_pkg::work_type              q_item
);

   localparam int SW = $clog2(REGION_GRANULES) + 1;
   localparam int XW = (SW > ifla_pkg::GRAN_W) ? SW : ifla_pkg::GRAN_W;

   logic [ifla_pkg::BYTES_W:0]    round_c;
   logic [ifla_pkg::NEED_W-1:0]   need_c;
   logic [ifla_pkg::GRAN_W-1:0]   gran_raw_c;
   logic [ifla_pkg::GRAN_W-1:0]   gran_c;
   logic                          outside_c;

   // granules needed: header plus the request rounded up
   assign round_c = {1'b0, req_if.request_bytes} + (ifla_pkg::BYTES_W + 1)'(7);
   assign need_c  = ifla_pkg::NEED_W'(round_c[ifla_pkg::BYTES_W:3]) + ifla_pkg::NEED_W'(1);

   // block start of a free: payload granule minus the header
   assign gran_raw_c = req_if.free_address[ifla_pkg::ADDR_W-1:3];
   assign gran_c     = gran_raw_c - ifla_pkg::GRAN_W'(1);
   assign outside_c  = XW'(gran_c) >= XW'(region_limit);

   // classify the beat
   always_comb begin
      q_item.style  = req_if.fit_style;
      q_item.need   = need_c;
      q_item.gran   = gran_c;
      q_item.status = ifla_pkg::STATUS_OK;
      if (req_if.command == ifla_pkg::CMD_ALLOC) begin
         q_item.kind = ifla_pkg::KIND_ALLOC;
      end else if (req_if.free_address == '0) begin
         q_item.kind   = ifla_pkg::KIND_REPLY;
         q_item.status = ifla_pkg::STATUS_NULL;
      end else if (gran_raw_c == '0 || outside_c) begin
         q_item.kind = ifla_pkg::KIND_REPLY;
      end else begin
         q_item.kind = ifla_pkg::KIND_FREE;
      end
   end

   assign req_if.ready = !q_full;
   assign q_push       = req_if.valid && !q_full;

endmodule

### hw/rtl/ifla_queue.sv
// Two-entry work queue between the front end and the back end.
// Depends on ifla_pkg for the work item type.
module ifla_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ifla_pkg::work_type push_item,
   output logic               full,
   input  logic               pop,
   output ifla_pkg::work_type pop_item,
   output logic               valid
);

   ifla_pkg::work_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign full     = count_ff == 2'd2;
   assign valid    = count_ff != 2'd0;
   assign pop_item = slot_ff[rd_ptr_ff];

endmodule

### hw/rtl/ifla_back.sv
// Back end: walks the header memory to carry out allocates and frees.
// Depends on ifla_pkg, ifla_rsp_if and ifla_ram.
module ifla_back #(
   parameter int REGION_GRANULES = ifla_pkg::REGION_GRANULES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [$clog2(REGION_GRANULES):0] region_limit,
   input  logic                            csr_load,
   input  logic                            q_valid,
   input  ifla_pkg::work_type              q_item,
   output logic                            q_pop,
   ifla_rsp_if.source                      rsp_if
);

   localparam int AW = $clog2(REGION_GRANULES);
   localparam int SW = AW + 1;
   localparam int CW = (SW > ifla_pkg::NEED_W) ? SW : ifla_pkg::NEED_W;

   typedef enum logic [3:0] {
      ST_IDLE, ST_A_WALK, ST_A_END, ST_A_MARK,
      ST_F_SELF, ST_F_NEXT, ST_F_BSTART, ST_F_WALK, ST_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic                         init_ff, init_in;
   logic                         found_ff, found_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                pos_ff, pos_in;
   logic [AW-1:0]                pick_ff, pick_in;
   logic [SW-1:0]                best_ff, best_in;
   logic [CW-1:0]                need_ff, need_in;
   logic [ifla_pkg::STYLE_W-1:0] style_ff, style_in;
   logic [AW-1:0]                gran_ff, gran_in;
   logic [SW-1:0]                gsize_ff, gsize_in;
   ifla_pkg::status_type         res_status_ff, res_status_in;
   logic [ifla_pkg::ADDR_W-1:0]  res_addr_ff, res_addr_in;
   ifla_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [ifla_pkg::ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [SW:0]                  wr_data;
   logic                         rd_en;
   logic [AW-1:0]                rd_addr;
   logic [SW:0]                  rd_data;

   logic [SW-1:0]                rd_size;
   logic                         rd_flag;
   logic                         brk_c;
   logic [SW:0]                  step_c;
   logic                         fits_c;
   logic                         better_c;
   logic [SW-1:0]                groom_c;
   logic [SW+2:0]                pay_c;

   ifla_ram #(.WIDTH(SW + 1), .DEPTH(REGION_GRANULES)) u_hdr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // decode the header just read
   assign rd_size  = rd_data[SW-1:0];
   assign rd_flag  = rd_data[SW];
   assign brk_c    = (rd_size == '0) || (rd_size > (region_limit - pos_ff));
   assign step_c   = {1'b0, pos_ff} + {1'b0, rd_size};
   assign fits_c   = rd_flag && (CW'(rd_size) >= need_ff);
   assign better_c = !found_ff ||
                     ((style_ff == ifla_pkg::FIT_BEST) ? (rd_size < best_ff) : (rd_size > best_ff));
   assign groom_c  = region_limit - SW'(gran_ff);
   assign pay_c    = ((SW + 3)'(pick_ff) + (SW + 3)'(1)) << 3;

   // sequence the walks
   always_comb begin
      state_in      = state_ff;
      init_in       = init_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      need_in       = need_ff;
      style_in      = style_ff;
      gran_in       = gran_ff;
      gsize_in      = gsize_ff;
      res_status_in = res_status_ff;
      res_addr_in   = res_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      q_pop         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (init_ff) begin
               wr_en   = 1'b1;
               wr_data = {1'b1, region_limit};
               init_in = 1'b0;
            end else if (q_valid) begin
               q_pop = 1'b1;
               case (q_item.kind)
                  ifla_pkg::KIND_ALLOC: begin
                     rd_en    = 1'b1;
                     pos_in   = '0;
                     found_in = 1'b0;
                     need_in  = CW'(q_item.need);
                     style_in = q_item.style;
                     state_in = ST_A_WALK;
                  end
                  ifla_pkg::KIND_FREE: begin
                     gran_in  = AW'(q_item.gran);
                     rd_en    = 1'b1;
                     rd_addr  = AW'(q_item.gran);
                     state_in = ST_F_SELF;
                  end
                  default: begin
                     res_status_in = q_item.status;
                     res_addr_in   = '0;
                     state_in      = ST_DONE;
                  end
               endcase
            end
         end
         ST_A_WALK: begin
            if (brk_c) begin
               state_in = ST_A_END;
            end else if (fits_c && style_ff == ifla_pkg::FIT_FIRST) begin
               pick_in  = AW'(pos_ff);
               best_in  = rd_size;
               found_in = 1'b1;
               state_in = ST_A_END;
            end else begin
               if (fits_c && better_c) begin
                  pick_in  = AW'(pos_ff);
                  best_in  = rd_size;
                  found_in = 1'b1;
               end
               pos_in = SW'(step_c);
               if (step_c >= {1'b0, region_limit}) begin
                  state_in = ST_A_END;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(step_c);
               end
            end
         end
         ST_A_END: begin
            if (!found_ff) begin
               res_status_in = ifla_pkg::STATUS_NO_SPACE;
               res_addr_in   = '0;
               state_in      = ST_DONE;
            end else begin
               // split off the surplus as a free block
               if (CW'(best_ff) > need_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = AW'(SW'(pick_ff) + SW'(need_ff));
                  wr_data = {1'b1, best_ff - SW'(need_ff)};
               end
               state_in = ST_A_MARK;
            end
         end
         ST_A_MARK: begin
            wr_en         = 1'b1;
            wr_addr       = pick_ff;
            wr_data       = {1'b0, SW'(need_ff)};
            res_status_in = ifla_pkg::STATUS_OK;
            res_addr_in   = ifla_pkg::ADDR_W'(pay_c);
            state_in      = ST_DONE;
         end
         ST_F_SELF: begin
            wr_en    = 1'b1;
            wr_addr  = gran_ff;
            wr_data  = {1'b1, rd_size};
            gsize_in = rd_size;
            if (rd_size != '0 && rd_size < groom_c) begin
               rd_en    = 1'b1;
               rd_addr  = AW'(SW'(gran_ff) + rd_size);
               state_in = ST_F_NEXT;
            end else begin
               state_in = ST_F_BSTART;
            end
         end
         ST_F_NEXT: begin
            // absorb a free next block
            if (rd_flag) begin
               gsize_in = gsize_ff + rd_size;
               wr_en    = 1'b1;
               wr_addr  = gran_ff;
               wr_data  = {1'b1, gsize_ff + rd_size};
            end
            state_in = ST_F_BSTART;
         end
         ST_F_BSTART: begin
            pos_in        = '0;
            res_status_in = ifla_pkg::STATUS_OK;
            res_addr_in   = '0;
            if (gran_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               state_in = ST_F_WALK;
            end
         end
         ST_F_WALK: begin
            if (brk_c) begin
               state_in = ST_DONE;
            end else if (rd_flag && step_c == {1'b0, SW'(gran_ff)}) begin
               // merge into the free block ending here
               wr_en    = 1'b1;
               wr_addr  = AW'(pos_ff);
               wr_data  = {1'b1, rd_size + gsize_ff};
               state_in = ST_DONE;
            end else begin
               pos_in = SW'(step_c);
               if (step_c >= {1'b0, SW'(gran_ff)}) begin
                  state_in = ST_DONE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(step_c);
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_addr_in   = res_addr_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_load) begin
         init_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         init_ff      <= 1'b1;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff        <= pos_in;
      pick_ff       <= pick_in;
      best_ff       <= best_in;
      need_ff       <= need_in;
      style_ff      <= style_in;
      gran_ff       <= gran_in;
      gsize_ff      <= gsize_in;
      res_status_ff <= res_status_in;
      res_addr_ff   <= res_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.status          = rsp_status_ff;
   assign rsp_if.payload_address = rsp_addr_ff;

   // header writes stay inside the region
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({1'b0, wr_addr} < region_limit))
      else $error("header write outside region");

   // failed beats carry a zero offset (frees also reply with a zero offset)
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ifla_pkg::STATUS_OK) |-> (rsp_addr_ff == '0))
      else $error("nonzero offset on failed beat");

   // no item starts before the initial header is written
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !init_ff)
      else $error("item taken before region init");

   // a chosen block is large enough
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_END && found_ff) |-> (CW'(best_ff) >= need_ff))
      else $error("picked block too small");

   // a pending init completes while idle unless a csr load renews it
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && init_ff && !csr_load) |=> !init_ff)
      else $error("region init stuck");

endmodule

### hw/rtl/implicit_free_list_allocator.sv
// Top level of the implicit free-list allocator: region register and the
// front end, work queue and back end. Depends on ifla_pkg, the interfaces and submodules.
//
//  channel   dir  handshake           payload
//  req_if    in   valid/ready         command, request_bytes, fit_style, free_address
//  rsp_if    out  valid/ready         status, payload_address
//  csr_*     in   csr_wr_en           csr_wr_data (region_pages)
//
// An allocate walks the block headers from the start of the region; a free reads
// its own header and, inside the region, the next one, then walks the blocks lying
// before it; a null, low or out-of-region free replies without a walk. The walk
// reads one header per cycle through the single read port of the header memory.
// After reset or a csr write, the back end writes the initial header once idle; no item starts before that.
// The queue takes beats while the back end walks, until it is full; a held response stalls the back end.
module implicit_free_list_allocator #(
   parameter int REGION_GRANULES = ifla_pkg::REGION_GRANULES,
   parameter int PAGE_GRANULES   = ifla_pkg::PAGE_GRANULES
) (
   input  logic                          clock,
   input  logic                          reset,
   ifla_req_if.sink                      req_if,
   ifla_rsp_if.source                    rsp_if,
   input  logic                          csr_wr_en,
   input  logic [ifla_pkg::PAGES_W-1:0]  csr_wr_data
);

   localparam int SW = $clog2(REGION_GRANULES) + 1;

   logic [SW-1:0]      region_limit_ff, region_limit_in;
   logic               q_push;
   logic               q_full;
   logic               q_pop;
   logic               q_valid;
   ifla_pkg::work_type push_item;
   ifla_pkg::work_type pop_item;

   // region size in granules from the page count
   always_comb begin
      region_limit_in = region_limit_ff;
      if (csr_wr_en) begin
         region_limit_in = SW'(ifla_pkg::region_granules(csr_wr_data, REGION_GRANULES,
                                                         PAGE_GRANULES));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_limit_ff <= SW'(ifla_pkg::region_granules(
                               ifla_pkg::PAGES_W'(ifla_pkg::RESET_PAGES),
                               REGION_GRANULES, PAGE_GRANULES));
      end else begin
         region_limit_ff <= region_limit_in;
      end
   end

   ifla_front #(.REGION_GRANULES(REGION_GRANULES)) u_front (
      .req_if       (req_if),
      .region_limit (region_limit_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_item       (push_item)
   );

   ifla_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .valid     (q_valid)
   );

   ifla_back #(.REGION_GRANULES(REGION_GRANULES)) u_back (
      .clock        (clock),
      .reset        (reset),
      .region_limit (region_limit_ff),
      .csr_load     (csr_wr_en),
      .q_valid      (q_valid),
      .q_item       (pop_item),
      .q_pop        (q_pop),
      .rsp_if       (rsp_if)
   );

endmodule
